// ===== hw/rtl/flcr_pkg.sv =====
// ----------------------------------------------------------------------------
// flcr_pkg
// Shared types and field layout for the line and circle rasterizer.
// ----------------------------------------------------------------------------
package flcr_pkg;

  localparam int MODE_W      = 3;
  localparam int IN_COORD_W  = 10;
  localparam int COORD_W     = 11;
  localparam int RADIUS_W    = 6;
  localparam int OFS_W       = 7;
  localparam int SQ_W        = 12;
  localparam int ERR_W       = 13;
  localparam int COLOR_W     = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int START_X_LSB = 0;
  localparam int START_Y_LSB = 10;
  localparam int END_X_LSB   = 20;
  localparam int END_Y_LSB   = 30;
  localparam int RADIUS_LSB  = 40;
  localparam int COLOR_LSB   = 46;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [SQ_W-1:0]           sq_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_PLOT   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_CIRCLE = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LINE,
    S_CIRCLE,
    S_RADDR,
    S_RDATA,
    S_PUSH
  } state_e;

endpackage

// ===== hw/rtl/framebuffer_line_circle_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// framebuffer_line_circle_rasterizer_core
// Drawing engine over a 16-bit frame store: clear, plot, line, filled circle
// and pixel read, with every write clipped to the frame.
// ----------------------------------------------------------------------------
// Commands enter on the slave stream; the mode travels in tuser, the
// coordinates, radius and pen color in tdata. Only a read returns a word on
// the master stream. A single sequencer walks each command one pixel per
// cycle through one address multiplier and the frame store's write port, so
// the block takes one command at a time and holds s_axis_tready_o low while
// it works. A read passes through the read address and read data states and
// then waits in a holding register until the output register is free, and
// the next command can be taken while the output word is still pending.
// Reset empties the sequencer and the output register; the frame store holds
// no defined value until a clear or a write reaches it.
// ----------------------------------------------------------------------------
module framebuffer_line_circle_rasterizer_core #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_x[9:0], start_y[19:10], end_x[29:20], end_y[39:30], radius[45:40],
  // pen_color[61:46], zero pad[63:62]
  input  logic [flcr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // mode[2:0]
  input  logic [flcr_pkg::MODE_W-1:0]        s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // read_color[15:0]
  output logic [flcr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  import flcr_pkg::*;

  localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);
  localparam coord_t XLIM = COORD_W'(FRAME_WIDTH);
  localparam coord_t YLIM = COORD_W'(FRAME_HEIGHT);
  localparam coord_t XLAST = COORD_W'(FRAME_WIDTH - 1);
  localparam coord_t YLAST = COORD_W'(FRAME_HEIGHT - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(FRAME_WIDTH);

  state_e state_q, state_d;

  coord_t lx_q, lx_d, ly_q, ly_d, ex_q, ex_d, ey_q, ey_d;
  coord_t ldx_q, ldx_d, ldy_q, ldy_d;
  logic   lsx_q, lsx_d, lsy_q, lsy_d;
  err_t   err_q, err_d;

  coord_t cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_W-1:0] r_q, r_d;
  ofs_t   xo_q, xo_d, yo_q, yo_d;
  sq_t    rr_q, rr_d, xx_q, xx_d, yy_q, yy_d;

  color_t color_q, color_d;

  logic   pix_v_q, pix_v_d, pix_rd_q, pix_rd_d;
  coord_t pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  color_t pix_c_q, pix_c_d;

  logic   rd_in_q;
  color_t res_q, res_d;
  logic   out_v_q, out_v_d;
  color_t out_q, out_d;

  mode_e  mode;
  coord_t in_sx, in_sy, in_ex, in_ey;
  logic [RADIUS_W-1:0] in_r;
  color_t in_c;

  logic   in_frame;
  logic [AW-1:0] addr;
  color_t rdata;

  logic signed [ERR_W:0] e2;
  logic   step_x, step_y;
  logic [SQ_W:0] sq_sum;
  ofs_t   r_ofs;
  logic signed [SQ_W+1:0] xx_nx, yy_nx;

  assign mode  = mode_e'(s_axis_tuser_i);
  assign in_sx = COORD_W'($signed(s_axis_tdata_i[START_X_LSB +: IN_COORD_W]));
  assign in_sy = COORD_W'($signed(s_axis_tdata_i[START_Y_LSB +: IN_COORD_W]));
  assign in_ex = COORD_W'($signed(s_axis_tdata_i[END_X_LSB +: IN_COORD_W]));
  assign in_ey = COORD_W'($signed(s_axis_tdata_i[END_Y_LSB +: IN_COORD_W]));
  assign in_r  = s_axis_tdata_i[RADIUS_LSB +: RADIUS_W];
  assign in_c  = s_axis_tdata_i[COLOR_LSB +: COLOR_W];

  assign in_frame = (pix_x_q >= 0) && (pix_x_q < XLIM) && (pix_y_q >= 0) && (pix_y_q < YLIM);
  assign addr     = AW'(pix_y_q[YW-1:0]) * ROW_STRIDE + AW'(pix_x_q[XW-1:0]);

  flcr_ram #(
    .DataW(COLOR_W),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (pix_v_q && !pix_rd_q && in_frame),
    .waddr_i(addr),
    .wdata_i(pix_c_q),
    .re_i   (pix_v_q && pix_rd_q),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  assign e2     = {err_q, 1'b0};
  assign step_x = e2 >= (ERR_W + 1)'(ldy_q);
  assign step_y = e2 <= (ERR_W + 1)'(ldx_q);
  assign sq_sum = {1'b0, xx_q} + {1'b0, yy_q};
  assign r_ofs  = $signed({1'b0, r_q});
  assign xx_nx  = $signed({2'b00, xx_q}) + (SQ_W + 2)'($signed({xo_q, 1'b1}));
  assign yy_nx  = $signed({2'b00, yy_q}) + (SQ_W + 2)'($signed({yo_q, 1'b1}));

  always_comb begin
    state_d  = state_q;
    lx_d     = lx_q;
    ly_d     = ly_q;
    ex_d     = ex_q;
    ey_d     = ey_q;
    ldx_d    = ldx_q;
    ldy_d    = ldy_q;
    lsx_d    = lsx_q;
    lsy_d    = lsy_q;
    err_d    = err_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    r_d      = r_q;
    xo_d     = xo_q;
    yo_d     = yo_q;
    rr_d     = rr_q;
    xx_d     = xx_q;
    yy_d     = yy_q;
    color_d  = color_q;
    pix_v_d  = 1'b0;
    pix_rd_d = 1'b0;
    pix_x_d  = pix_x_q;
    pix_y_d  = pix_y_q;
    pix_c_d  = color_q;
    res_d    = res_q;
    out_v_d  = out_v_q && !m_axis_tready_i;
    out_d    = out_q;
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          color_d = in_c;
          case (mode)
            MODE_CLEAR: begin
              lx_d    = '0;
              ly_d    = '0;
              state_d = S_CLEAR;
            end
            MODE_PLOT: begin
              pix_v_d = 1'b1;
              pix_x_d = in_sx;
              pix_y_d = in_sy;
              pix_c_d = in_c;
            end
            MODE_LINE: begin
              lx_d    = in_sx;
              ly_d    = in_sy;
              ex_d    = in_ex;
              ey_d    = in_ey;
              ldx_d   = (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
              ldy_d   = (in_ey > in_sy) ? in_sy - in_ey : in_ey - in_sy;
              lsx_d   = in_sx < in_ex;
              lsy_d   = in_sy < in_ey;
              err_d   = ERR_W'(ldx_d) + ERR_W'(ldy_d);
              state_d = S_LINE;
            end
            MODE_CIRCLE: begin
              cx_d    = in_sx;
              cy_d    = in_sy;
              r_d     = in_r;
              rr_d    = SQ_W'(in_r) * SQ_W'(in_r);
              xx_d    = rr_d;
              yy_d    = rr_d;
              xo_d    = -$signed({1'b0, in_r});
              yo_d    = -$signed({1'b0, in_r});
              state_d = S_CIRCLE;
            end
            MODE_READ: begin
              pix_v_d  = 1'b1;
              pix_rd_d = 1'b1;
              pix_x_d  = in_sx;
              pix_y_d  = in_sy;
              state_d  = S_RADDR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_CLEAR: begin
        pix_v_d = 1'b1;
        pix_x_d = lx_q;
        pix_y_d = ly_q;
        if (lx_q == XLAST) begin
          lx_d = '0;
          ly_d = ly_q + COORD_W'(1);
          if (ly_q == YLAST) begin
            state_d = S_IDLE;
          end
        end else begin
          lx_d = lx_q + COORD_W'(1);
        end
      end

      S_LINE: begin
        pix_v_d = 1'b1;
        pix_x_d = lx_q;
        pix_y_d = ly_q;
        if (lx_q == ex_q && ly_q == ey_q) begin
          state_d = S_IDLE;
        end else begin
          err_d = err_q + (step_x ? ERR_W'(ldy_q) : '0) + (step_y ? ERR_W'(ldx_q) : '0);
          if (step_x) begin
            lx_d = lsx_q ? lx_q + COORD_W'(1) : lx_q - COORD_W'(1);
          end
          if (step_y) begin
            ly_d = lsy_q ? ly_q + COORD_W'(1) : ly_q - COORD_W'(1);
          end
        end
      end

      S_CIRCLE: begin
        pix_v_d = sq_sum <= {1'b0, rr_q};
        pix_x_d = cx_q + COORD_W'(xo_q);
        pix_y_d = cy_q + COORD_W'(yo_q);
        if (xo_q == r_ofs) begin
          xo_d = -r_ofs;
          xx_d = rr_q;
          if (yo_q == r_ofs) begin
            state_d = S_IDLE;
          end else begin
            yo_d = yo_q + OFS_W'(1);
            yy_d = yy_nx[SQ_W-1:0];
          end
        end else begin
          xo_d = xo_q + OFS_W'(1);
          xx_d = xx_nx[SQ_W-1:0];
        end
      end

      S_RADDR: begin
        state_d = S_RDATA;
      end

      S_RDATA: begin
        res_d   = rd_in_q ? rdata : '0;
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (!out_v_q || m_axis_tready_i) begin
          out_v_d = 1'b1;
          out_d   = res_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pix_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pix_v_q <= pix_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q     <= lx_d;
    ly_q     <= ly_d;
    ex_q     <= ex_d;
    ey_q     <= ey_d;
    ldx_q    <= ldx_d;
    ldy_q    <= ldy_d;
    lsx_q    <= lsx_d;
    lsy_q    <= lsy_d;
    err_q    <= err_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    r_q      <= r_d;
    xo_q     <= xo_d;
    yo_q     <= yo_d;
    rr_q     <= rr_d;
    xx_q     <= xx_d;
    yy_q     <= yy_d;
    color_q  <= color_d;
    pix_rd_q <= pix_rd_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
    pix_c_q  <= pix_c_d;
    rd_in_q  <= in_frame;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ===== hw/rtl/flcr_ram.sv =====
// ----------------------------------------------------------------------------
// flcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flcr_ram #(
  parameter int DataW = 16,
  parameter int Depth = 57600
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line and circle rasterizer. A queue of draw
// commands (clears, plots, lines, filled circles, reads and unused modes) is
// streamed in with random gaps. A software copy of the frame store is updated
// as each word is accepted, and every read word on the output stream is
// compared with the color that the copy holds at that position.
// ----------------------------------------------------------------------------
module testbench;
  import flcr_pkg::*;

  localparam int FRAME_W       = 240;
  localparam int FRAME_H       = 240;
  localparam int N_RANDOM      = 1000;
  localparam int HOLD_AT       = 16;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 64;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]            mode;
    logic signed [IN_COORD_W-1:0] sx;
    logic signed [IN_COORD_W-1:0] sy;
    logic signed [IN_COORD_W-1:0] ex;
    logic signed [IN_COORD_W-1:0] ey;
    logic [RADIUS_W-1:0]          radius;
    logic [COLOR_W-1:0]           pen;
    bit                           drain;
  } draw_cmd_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [MODE_W-1:0]      s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  draw_cmd_t        draw_cmds[$];
  draw_cmd_t        cmd_on_bus;
  logic [COLOR_W-1:0] read_colors_due[$];
  logic [COLOR_W-1:0] frame_copy[0:FRAME_W*FRAME_H-1];
  int               n_errors = 0;
  int               cmds_taken = 0;
  bit               cmd_fire = 1'b0;

  framebuffer_line_circle_rasterizer_core #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [IN_COORD_W-1:0] coord_in(int lo, int hi);
    return IN_COORD_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic draw_cmd_t cmd_of(logic [MODE_W-1:0] m, int sx, int sy, int ex,
                                       int ey, int r, int pen, bit drain = 1'b0);
    draw_cmd_t c;
    c.mode   = m;
    c.sx     = IN_COORD_W'(sx);
    c.sy     = IN_COORD_W'(sy);
    c.ex     = IN_COORD_W'(ex);
    c.ey     = IN_COORD_W'(ey);
    c.radius = RADIUS_W'(r);
    c.pen    = COLOR_W'(pen);
    c.drain  = drain;
    return c;
  endfunction

  function automatic bit in_frame(int x, int y);
    return x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H;
  endfunction

  function automatic void paint(int x, int y, logic [COLOR_W-1:0] c);
    if (in_frame(x, y)) frame_copy[y*FRAME_W + x] = c;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] c);
    int dx, dy, stx, sty, err, e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
    stx = (x0 < x1) ? 1 : -1;
    sty = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      paint(x0, y0, c);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += stx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sty;
      end
    end
  endfunction

  function automatic void fill_disc(int cx, int cy, int r, logic [COLOR_W-1:0] c);
    for (int y = -r; y <= r; y++) begin
      for (int x = -r; x <= r; x++) begin
        if (x*x + y*y <= r*r) paint(cx + x, cy + y, c);
      end
    end
  endfunction

  function automatic void render_command(draw_cmd_t c);
    int sx, sy;
    sx = int'(c.sx);
    sy = int'(c.sy);
    case (c.mode)
      MODE_CLEAR: begin
        foreach (frame_copy[i]) frame_copy[i] = c.pen;
      end
      MODE_PLOT:   paint(sx, sy, c.pen);
      MODE_LINE:   trace_line(sx, sy, int'(c.ex), int'(c.ey), c.pen);
      MODE_CIRCLE: fill_disc(sx, sy, int'(c.radius), c.pen);
      MODE_READ: begin
        read_colors_due.push_back(in_frame(sx, sy) ? frame_copy[sy*FRAME_W + sx] : '0);
      end
      default: ;
    endcase
  endfunction

  // monitor: check read words, then take in the accepted command
  always @(posedge clk_i) begin
    logic [COLOR_W-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (read_colors_due.size() == 0) begin
          $error("read_color: expected none, got %h", m_axis_tdata_o);
          n_errors++;
        end else begin
          want = read_colors_due.pop_front();
          if (m_axis_tdata_o !== want) begin
            $error("read_color: expected %h, got %h", want, m_axis_tdata_o);
            n_errors++;
          end
        end
      end
      cmd_fire = s_axis_tvalid_i && s_axis_tready_o;
      if (cmd_fire) begin
        render_command(cmd_on_bus);
        cmds_taken++;
      end
    end
  end

  // driver
  int drv_gap = 0;
  int drv_calm = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid_i && !cmd_fire)) begin
        if (cmd_fire) begin
          if (drv_calm > 0) begin
            drv_calm--;
            drv_gap = 0;
          end else begin
            drv_gap = idle_len();
            if ($urandom_range(0, 31) == 0) drv_calm = $urandom_range(10, 60);
          end
        end
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (draw_cmds.size() != 0 &&
                     (!draw_cmds[0].drain || read_colors_due.size() == 0)) begin
          cmd_on_bus = draw_cmds.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= cmd_on_bus.mode;
          s_axis_tdata_i  <= {2'b00, cmd_on_bus.pen, cmd_on_bus.radius, cmd_on_bus.ey,
                              cmd_on_bus.ex, cmd_on_bus.sy, cmd_on_bus.sx};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  int sink_hold = 0;
  bit sink_hold_done = 1'b0;
  int sink_stall = 0;
  int sink_calm = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (!sink_hold_done && cmds_taken >= HOLD_AT) begin
        sink_hold_done = 1'b1;
        sink_hold      = LONG_HOLD - 1;
        m_axis_tready_i <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_calm == 0 && $urandom_range(0, 7) == 0) begin
        sink_stall = idle_len();
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 255) == 0) sink_calm = $urandom_range(50, 400);
      end
    end
  end

  initial begin
    draw_cmd_t cmd;
    int        pick;
    int        n_made;
    int        last_x;
    int        last_y;

    draw_cmds.push_back(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0, 'hA5C3));
    draw_cmds.push_back(cmd_of(MODE_READ, 0, 0, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 239, 239, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_PLOT, 0, 0, 0, 0, 0, 'hFFFF));
    draw_cmds.push_back(cmd_of(MODE_PLOT, 239, 239, 0, 0, 0, 'h0000));
    draw_cmds.push_back(cmd_of(MODE_PLOT, -1, 5, 0, 0, 0, 'h1234));
    draw_cmds.push_back(cmd_of(MODE_PLOT, 240, 0, 0, 0, 0, 'h4321));
    draw_cmds.push_back(cmd_of(MODE_LINE, -512, -512, 511, 511, 0, 'h5555));
    draw_cmds.push_back(cmd_of(MODE_LINE, 200, 10, 10, 200, 0, 'hAAAA));
    draw_cmds.push_back(cmd_of(MODE_LINE, 100, 100, 100, 100, 0, 'h0F0F));
    draw_cmds.push_back(cmd_of(MODE_LINE, 5, 230, 9, 3, 0, 'hF00F));
    draw_cmds.push_back(cmd_of(MODE_CIRCLE, 120, 120, 0, 0, 0, 'h07E0));
    draw_cmds.push_back(cmd_of(MODE_CIRCLE, 0, 239, 0, 0, 63, 'hF800));
    draw_cmds.push_back(cmd_of(MODE_CIRCLE, -3, 50, 0, 0, 5, 'h001F));
    draw_cmds.push_back(cmd_of(MODE_UNUSED_LO, 7, 7, 0, 0, 0, 'hDEAD));
    draw_cmds.push_back(cmd_of(MODE_UNUSED_HI, 8, 8, 0, 0, 0, 'hBEEF));
    // read burst while the receiver holds off
    draw_cmds.push_back(cmd_of(MODE_READ, 0, 0, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 239, 239, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, -1, 5, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 511, -512, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 120, 120, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 100, 100, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 7, 150, 0, 0, 0, 0));
    draw_cmds.push_back(cmd_of(MODE_READ, 2, 50, 0, 0, 0, 0, 1'b1));

    n_made = 0;
    last_x = 120;
    last_y = 120;
    while (n_made < N_RANDOM) begin
      cmd.sx     = IN_COORD_W'($urandom());
      cmd.sy     = IN_COORD_W'($urandom());
      cmd.ex     = IN_COORD_W'($urandom());
      cmd.ey     = IN_COORD_W'($urandom());
      cmd.radius = RADIUS_W'($urandom());
      cmd.pen    = COLOR_W'($urandom());
      cmd.drain  = ($urandom_range(0, 49) == 0);
      pick       = $urandom_range(0, 99);
      if (n_made == 300 || n_made == 650 || n_made == 900) begin
        cmd.mode = MODE_CLEAR;
        if (n_made == 300) cmd.pen = '0;
        else if (n_made == 650) cmd.pen = '1;
      end else if (pick < 40) begin
        cmd.mode = MODE_READ;
        case ($urandom_range(0, 9))
          0: ;
          1, 2, 3, 4: begin
            cmd.sx = coord_in(0, FRAME_W - 1);
            cmd.sy = coord_in(0, FRAME_H - 1);
          end
          default: begin
            cmd.sx = coord_in(last_x - 3, last_x + 3);
            cmd.sy = coord_in(last_y - 3, last_y + 3);
          end
        endcase
      end else if (pick < 60) begin
        cmd.mode = MODE_PLOT;
        if ($urandom_range(0, 99) < 85) begin
          cmd.sx = coord_in(0, FRAME_W - 1);
          cmd.sy = coord_in(0, FRAME_H - 1);
        end
        last_x = int'(cmd.sx);
        last_y = int'(cmd.sy);
      end else if (pick < 80) begin
        cmd.mode = MODE_LINE;
        if ($urandom_range(0, 9) != 0) begin
          cmd.sx = coord_in(-8, FRAME_W + 8);
          cmd.sy = coord_in(-8, FRAME_H + 8);
          cmd.ex = coord_in(int'(cmd.sx) - 30, int'(cmd.sx) + 30);
          cmd.ey = coord_in(int'(cmd.sy) - 30, int'(cmd.sy) + 30);
        end
        last_x = int'(cmd.ex);
        last_y = int'(cmd.ey);
      end else if (pick < 97) begin
        cmd.mode = MODE_CIRCLE;
        if ($urandom_range(0, 99) < 85) begin
          cmd.sx = coord_in(-12, FRAME_W + 12);
          cmd.sy = coord_in(-12, FRAME_H + 12);
        end
        if ($urandom_range(0, 99) < 95) cmd.radius = RADIUS_W'($urandom_range(0, 9));
        last_x = int'(cmd.sx);
        last_y = int'(cmd.sy);
      end else begin
        cmd.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      end
      draw_cmds.push_back(cmd);
      if (cmd.mode <= MODE_READ) n_made++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (draw_cmds.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (read_colors_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && read_colors_due.size() == 0) begin
      $display("framebuffer_line_circle_rasterizer_core: match");
    end else begin
      $display("framebuffer_line_circle_rasterizer_core: mismatch");
    end
    $finish;
  end

  initial begin
    #32_000_000;
    $display("framebuffer_line_circle_rasterizer_core: mismatch");
    $finish;
  end

endmodule
